// ===== hw/rtl/hbt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types and constants for the homography bilinear tap generator.
// ----------------------------------------------------------------------------
package hbt_pkg;

  localparam int COEF_W   = 21;   // one packed matrix coefficient
  localparam int ROW_W    = 63;   // three coefficients per row register
  localparam int COORD_W  = 12;   // pixel coordinate width
  localparam int WEIGHT_W = 17;   // Q1.16 weight, one included
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = 34;   // coefficient times coordinate
  localparam int DOT_W    = 36;   // two products plus the constant coefficient
  localparam int W_SHIFT  = 9;    // Q.10 over Q.19 gives a Q.-9 quotient
  localparam int SRC_LAST = 4095;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 63'h400_0000_0000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 63'h20_0000;
  localparam logic [ROW_W-1:0] ROW_W_RESET = 63'h8_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_W = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CLAMPED  = 2'd1,
    STATUS_ZERO_DEN = 2'd2
  } map_status_t;

  // Coefficient 0 sits in the top bits of a row register.
  function automatic logic signed [COEF_W-1:0] coef(logic [ROW_W-1:0] row, int slot);
    logic signed [COEF_W-1:0] c;
    case (slot)
      0: c = row[62:42];
      1: c = row[41:21];
      default: c = row[20:0];
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/hbt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// hbt_cfg_if
// Register write channel: index and data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hbt_pkg::CFG_IDX_W-1:0]   index;
  logic [hbt_pkg::ROW_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hbt_in_if.sv =====
// ----------------------------------------------------------------------------
// hbt_in_if
// Output pixel coordinate stream, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbt_in_if;
  logic                          valid;
  logic                          ready;
  logic [hbt_pkg::COORD_W-1:0]   out_x;
  logic [hbt_pkg::COORD_W-1:0]   out_y;

  modport source (output valid, out_x, out_y, input ready);
  modport sink   (input valid, out_x, out_y, output ready);
endinterface

// ===== hw/rtl/hbt_out_if.sv =====
// ----------------------------------------------------------------------------
// hbt_out_if
// Source taps and bilinear weights stream, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbt_out_if;
  logic                           valid;
  logic                           ready;
  logic [hbt_pkg::COORD_W-1:0]    src_x_low;
  logic [hbt_pkg::COORD_W-1:0]    src_x_high;
  logic [hbt_pkg::COORD_W-1:0]    src_y_low;
  logic [hbt_pkg::COORD_W-1:0]    src_y_high;
  logic [hbt_pkg::WEIGHT_W-1:0]   weight_ll;
  logic [hbt_pkg::WEIGHT_W-1:0]   weight_lh;
  logic [hbt_pkg::WEIGHT_W-1:0]   weight_hl;
  logic [hbt_pkg::WEIGHT_W-1:0]   weight_hh;
  logic [1:0]                     map_status;

  modport source (output valid, src_x_low, src_x_high, src_y_low, src_y_high,
                  weight_ll, weight_lh, weight_hl, weight_hh, map_status,
                  input ready);
  modport sink   (input valid, src_x_low, src_x_high, src_y_low, src_y_high,
                  weight_ll, weight_lh, weight_hl, weight_hh, map_status,
                  output ready);
endinterface

// ===== hw/rtl/homography_bilinear_taps.sv =====
// ----------------------------------------------------------------------------
// homography_bilinear_taps
// Maps output pixels through an inverse homography and emits bilinear taps.
// ----------------------------------------------------------------------------
// Stages: saturate, products, dot sums, divider load, the one-bit-per-stage
//   restoring divider for both quotients, floor fix, taps, output register.
// Throughput: one pixel per cycle; the whole pipe holds while a result waits.
// Reset: synchronous; clears all stage valid bits and loads the identity-like
//   default rows. Config writes are always taken (ready tied high).
module homography_bilinear_taps #(
  parameter int MAX_OUT_WIDTH  = 4096,
  parameter int MAX_OUT_HEIGHT = 4096,
  parameter int FRAC_BITS      = 8
) (
  input  logic       clk,
  input  logic       rst,
  hbt_cfg_if.sink    cfg,
  hbt_in_if.sink     pix_in,
  hbt_out_if.source  taps_out
);

  localparam int NW = hbt_pkg::DOT_W;
  localparam int DW = NW + hbt_pkg::W_SHIFT + FRAC_BITS;
  localparam int PW = DW + 1;
  localparam int CW = PW - FRAC_BITS + 1;
  localparam int XLIM = (MAX_OUT_WIDTH  > 4096) ? 4096 : MAX_OUT_WIDTH;
  localparam int YLIM = (MAX_OUT_HEIGHT > 4096) ? 4096 : MAX_OUT_HEIGHT;
  localparam logic [hbt_pkg::COORD_W-1:0] X_LAST = hbt_pkg::COORD_W'(XLIM - 1);
  localparam logic [hbt_pkg::COORD_W-1:0] Y_LAST = hbt_pkg::COORD_W'(YLIM - 1);

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] dvd;
    logic [DW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic          neg_x;
    logic          neg_y;
    logic          zero_den;
    logic [NW-1:0] den;
    lane_t         lx;
    lane_t         ly;
  } div_stage_t;

  typedef struct packed {
    logic                            clamped;
    logic [hbt_pkg::COORD_W-1:0]     lo;
    logic [hbt_pkg::COORD_W-1:0]     hi;
    logic [hbt_pkg::WEIGHT_W-1:0]    wlo;
    logic [hbt_pkg::WEIGHT_W-1:0]    whi;
  } axis_t;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  function automatic lane_t div_step(lane_t l, logic [NW-1:0] d);
    logic [NW:0] t;
    lane_t r;
    t     = {l.rem, l.dvd[DW-1]};
    r.dvd = {l.dvd[DW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = NW'(t - {1'b0, d});
      r.quo = {l.quo[DW-2:0], 1'b1};
    end else begin
      r.rem = t[NW-1:0];
      r.quo = {l.quo[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic axis_t axis_split(logic signed [PW-1:0] p);
    logic [FRAC_BITS-1:0] frac;
    logic signed [CW-1:0] fl;
    logic signed [CW-1:0] cl;
    logic signed [CW-1:0] last;
    axis_t a;
    frac = p[FRAC_BITS-1:0];
    last = CW'(hbt_pkg::SRC_LAST);
    fl   = CW'(p >>> FRAC_BITS);
    cl   = fl + $signed(CW'(frac != '0));
    a.clamped = fl[CW-1] || (cl > last);
    if (fl[CW-1])       a.lo = '0;
    else if (fl > last) a.lo = hbt_pkg::COORD_W'(hbt_pkg::SRC_LAST);
    else                a.lo = fl[hbt_pkg::COORD_W-1:0];
    if (cl[CW-1])       a.hi = '0;
    else if (cl > last) a.hi = hbt_pkg::COORD_W'(hbt_pkg::SRC_LAST);
    else                a.hi = cl[hbt_pkg::COORD_W-1:0];
    a.whi = (frac != '0) ? (hbt_pkg::WEIGHT_W'(frac) << (16 - FRAC_BITS))
                         : hbt_pkg::ONE_Q16;
    a.wlo = hbt_pkg::ONE_Q16 - a.whi;
    return a;
  endfunction

  logic ce;

  // ---------------- configuration ----------------
  logic [hbt_pkg::ROW_W-1:0] row_x;
  logic [hbt_pkg::ROW_W-1:0] row_y;
  logic [hbt_pkg::ROW_W-1:0] row_w;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= hbt_pkg::ROW_X_RESET;
      row_y <= hbt_pkg::ROW_Y_RESET;
      row_w <= hbt_pkg::ROW_W_RESET;
    end else if (cfg.valid) begin
      case (hbt_pkg::cfg_index_t'(cfg.index))
        hbt_pkg::CFG_ROW_X: row_x <= cfg.data;
        hbt_pkg::CFG_ROW_Y: row_y <= cfg.data;
        hbt_pkg::CFG_ROW_W: row_w <= cfg.data;
        default: ;
      endcase
    end
  end

  // Hold every stage while the output register is full and not taken.
  assign ce           = !taps_out.valid || taps_out.ready;
  assign pix_in.ready = ce;

  // ---------------- stage 1: saturate coordinates ----------------
  logic                        v1;
  logic [hbt_pkg::COORD_W-1:0] x1;
  logic [hbt_pkg::COORD_W-1:0] y1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ce) v1 <= pix_in.valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x1 <= (pix_in.out_x > X_LAST) ? X_LAST : pix_in.out_x;
      y1 <= (pix_in.out_y > Y_LAST) ? Y_LAST : pix_in.out_y;
    end
  end

  // ---------------- stage 2: products ----------------
  logic                              v2;
  logic signed [hbt_pkg::PROD_W-1:0] px0, px1, py0, py1, pw0, pw1;
  logic signed [hbt_pkg::COORD_W:0]  xs;
  logic signed [hbt_pkg::COORD_W:0]  ys;

  assign xs = {1'b0, x1};
  assign ys = {1'b0, y1};

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (ce) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      px0 <= hbt_pkg::PROD_W'(hbt_pkg::coef(row_x, 0) * xs);
      px1 <= hbt_pkg::PROD_W'(hbt_pkg::coef(row_x, 1) * ys);
      py0 <= hbt_pkg::PROD_W'(hbt_pkg::coef(row_y, 0) * xs);
      py1 <= hbt_pkg::PROD_W'(hbt_pkg::coef(row_y, 1) * ys);
      pw0 <= hbt_pkg::PROD_W'(hbt_pkg::coef(row_w, 0) * xs);
      pw1 <= hbt_pkg::PROD_W'(hbt_pkg::coef(row_w, 1) * ys);
    end
  end

  // ---------------- stage 3: dot products ----------------
  logic                 v3;
  logic signed [NW-1:0] nx, ny, dw;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (ce) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nx <= NW'(px0) + NW'(px1) + NW'(hbt_pkg::coef(row_x, 2));
      ny <= NW'(py0) + NW'(py1) + NW'(hbt_pkg::coef(row_y, 2));
      dw <= NW'(pw0) + NW'(pw1) + NW'(hbt_pkg::coef(row_w, 2));
    end
  end

  // ---------------- stage 4 and divider ----------------
  div_stage_t dv [DW+1];

  logic [NW-1:0] mag_x, mag_y, mag_w;
  assign mag_x = nx[NW-1] ? NW'(-nx) : NW'(nx);
  assign mag_y = ny[NW-1] ? NW'(-ny) : NW'(ny);
  assign mag_w = dw[NW-1] ? NW'(-dw) : NW'(dw);

  always_ff @(posedge clk) begin
    if (rst) dv[0].valid <= 1'b0;
    else if (ce) dv[0].valid <= v3;
    if (ce) begin
      dv[0].neg_x    <= nx[NW-1] ^ dw[NW-1];
      dv[0].neg_y    <= ny[NW-1] ^ dw[NW-1];
      dv[0].zero_den <= (dw == '0);
      dv[0].den      <= mag_w;
      dv[0].lx       <= '{rem: '0, dvd: {mag_x, (DW-NW)'(0)}, quo: '0};
      dv[0].ly       <= '{rem: '0, dvd: {mag_y, (DW-NW)'(0)}, quo: '0};
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv[k+1].valid <= 1'b0;
      else if (ce) dv[k+1].valid <= dv[k].valid;
      if (ce) begin
        dv[k+1].neg_x    <= dv[k].neg_x;
        dv[k+1].neg_y    <= dv[k].neg_y;
        dv[k+1].zero_den <= dv[k].zero_den;
        dv[k+1].den      <= dv[k].den;
        dv[k+1].lx       <= div_step(dv[k].lx, dv[k].den);
        dv[k+1].ly       <= div_step(dv[k].ly, dv[k].den);
      end
    end
  end

  // ---------------- floor correction and sign ----------------
  logic                 v5, zd5;
  logic signed [PW-1:0] p_x, p_y;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (ce) v5 <= dv[DW].valid;
  end

  // Negative quotients round toward minus infinity: bump magnitude on remainder.
  always_ff @(posedge clk) begin
    if (ce) begin
      zd5 <= dv[DW].zero_den;
      p_x <= dv[DW].neg_x
           ? -(PW'(dv[DW].lx.quo) + PW'(dv[DW].lx.rem != '0))
           : PW'(dv[DW].lx.quo);
      p_y <= dv[DW].neg_y
           ? -(PW'(dv[DW].ly.quo) + PW'(dv[DW].ly.rem != '0))
           : PW'(dv[DW].ly.quo);
    end
  end

  // ---------------- taps, clamp and axis weights ----------------
  logic                  v6;
  axis_t                 ax, ay;
  hbt_pkg::map_status_t  st6;
  axis_t                 ax_c, ay_c;

  assign ax_c = axis_split(p_x);
  assign ay_c = axis_split(p_y);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (ce) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (zd5) begin
        ax  <= '0;
        ay  <= '0;
        st6 <= hbt_pkg::STATUS_ZERO_DEN;
      end else begin
        ax  <= ax_c;
        ay  <= ay_c;
        st6 <= (ax_c.clamped || ay_c.clamped) ? hbt_pkg::STATUS_CLAMPED
                                              : hbt_pkg::STATUS_OK;
      end
    end
  end

  // ---------------- output register: tap weights ----------------
  logic [2*hbt_pkg::WEIGHT_W-1:0] m_ll, m_lh, m_hl, m_hh;

  assign m_ll = ax.wlo * ay.wlo;
  assign m_lh = ax.wlo * ay.whi;
  assign m_hl = ax.whi * ay.wlo;
  assign m_hh = ax.whi * ay.whi;

  always_ff @(posedge clk) begin
    if (rst) taps_out.valid <= 1'b0;
    else if (ce) taps_out.valid <= v6;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      taps_out.src_x_low  <= ax.lo;
      taps_out.src_x_high <= ax.hi;
      taps_out.src_y_low  <= ay.lo;
      taps_out.src_y_high <= ay.hi;
      taps_out.weight_ll  <= m_ll[16 +: hbt_pkg::WEIGHT_W];
      taps_out.weight_lh  <= m_lh[16 +: hbt_pkg::WEIGHT_W];
      taps_out.weight_hl  <= m_hl[16 +: hbt_pkg::WEIGHT_W];
      taps_out.weight_hh  <= m_hh[16 +: hbt_pkg::WEIGHT_W];
      taps_out.map_status <= st6;
    end
  end

  // ---------------- assertions ----------------
  logic [hbt_pkg::WEIGHT_W+1:0] weight_sum;
  assign weight_sum = (hbt_pkg::WEIGHT_W+2)'(taps_out.weight_ll)
                    + (hbt_pkg::WEIGHT_W+2)'(taps_out.weight_lh)
                    + (hbt_pkg::WEIGHT_W+2)'(taps_out.weight_hl)
                    + (hbt_pkg::WEIGHT_W+2)'(taps_out.weight_hh);

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!taps_out.valid || taps_out.ready) |-> pix_in.ready)
    else $error("input stalled while output register is free");

  a_zero_den_clear: assert property (@(posedge clk) disable iff (rst)
    (taps_out.valid && taps_out.map_status == hbt_pkg::STATUS_ZERO_DEN) |->
    (weight_sum == '0 && taps_out.src_x_low == '0 && taps_out.src_y_high == '0))
    else $error("zero denominator result carries nonzero fields");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    taps_out.valid |-> (weight_sum <= (hbt_pkg::WEIGHT_W+2)'(hbt_pkg::ONE_Q16)))
    else $error("tap weights sum above one");

  a_integral_hit: assert property (@(posedge clk) disable iff (rst)
    (taps_out.valid && taps_out.map_status != hbt_pkg::STATUS_ZERO_DEN &&
     taps_out.weight_hh == hbt_pkg::ONE_Q16) |->
    (taps_out.weight_ll == '0 && taps_out.weight_lh == '0 && taps_out.weight_hl == '0))
    else $error("integral source point leaves weight on low taps");

  a_ok_span: assert property (@(posedge clk) disable iff (rst)
    (taps_out.valid && taps_out.map_status == hbt_pkg::STATUS_OK) |->
    ((taps_out.src_x_high == taps_out.src_x_low ||
      taps_out.src_x_high == taps_out.src_x_low + 1'b1) &&
     (taps_out.src_y_high == taps_out.src_y_low ||
      taps_out.src_y_high == taps_out.src_y_low + 1'b1)))
    else $error("unclamped taps more than one pixel apart");

endmodule

// ===== tb/sv/tb_homography_bilinear_taps.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_homography_bilinear_taps
// Self-checking bench for the homography bilinear tap generator.
// Drives pixel coordinates under several matrix settings, predicts the taps,
// weights and status of every pixel, and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_homography_bilinear_taps;

  localparam int DRAIN_CYCLES = 70;
  localparam logic [hbt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [hbt_pkg::COORD_W-1:0]  x_low, x_high, y_low, y_high;
    logic [hbt_pkg::WEIGHT_W-1:0] w_ll, w_lh, w_hl, w_hh;
    hbt_pkg::map_status_t         status;
  } taps_t;

  typedef struct {
    logic [hbt_pkg::COORD_W-1:0] x, y;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hbt_cfg_if cfg_bus ();
  hbt_in_if  pix_bus ();
  hbt_out_if taps_bus ();

  homography_bilinear_taps u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_bus),
    .pix_in   (pix_bus),
    .taps_out (taps_bus)
  );

  always #4 clk = ~clk;

  logic [hbt_pkg::ROW_W-1:0] row_x = hbt_pkg::ROW_X_RESET;
  logic [hbt_pkg::ROW_W-1:0] row_y = hbt_pkg::ROW_Y_RESET;
  logic [hbt_pkg::ROW_W-1:0] row_w = hbt_pkg::ROW_W_RESET;

  pixel_t pixel_queue[$];
  taps_t  taps_expected[$];
  int     errors = 0;
  int     pixels_sent = 0;
  int     taps_seen = 0;
  int     status_seen[3] = '{0, 0, 0};
  int     stall_left = 0;
  bit     stall_done = 1'b0;
  bit     offer_taken = 1'b0;
  bit     steady = 1'b0;

  function automatic longint coef_of(logic [hbt_pkg::ROW_W-1:0] r, int slot);
    logic signed [hbt_pkg::COEF_W-1:0] c;
    c = r[62 - 21*slot -: 21];
    return longint'(c);
  endfunction

  function automatic longint row_sum(logic [hbt_pkg::ROW_W-1:0] r, longint x, longint y);
    return coef_of(r, 0) * x + coef_of(r, 1) * y + coef_of(r, 2);
  endfunction

  // floor(num * 2^(9+8) / den)
  function automatic longint floor_quot(longint num, longint den);
    longint unsigned un, ud, q, rem;
    un = longint'(num < 0 ? -num : num) << (hbt_pkg::W_SHIFT + 8);
    ud = longint'(den < 0 ? -den : den);
    q = un / ud;
    rem = un % ud;
    if ((num < 0) != (den < 0)) return -longint'(q + (rem != 0));
    return longint'(q);
  endfunction

  function automatic void split_axis(input longint p,
                                     output logic [hbt_pkg::COORD_W-1:0] lo,
                                     output logic [hbt_pkg::COORD_W-1:0] hi,
                                     output longint wlo, output longint whi,
                                     inout bit clamped);
    longint fr, fl, cl;
    fr = p & 255;
    fl = p >>> 8;
    cl = fl + (fr != 0);
    if (fl < 0 || cl > hbt_pkg::SRC_LAST) clamped = 1'b1;
    fl = fl < 0 ? 0 : (fl > hbt_pkg::SRC_LAST ? hbt_pkg::SRC_LAST : fl);
    cl = cl < 0 ? 0 : (cl > hbt_pkg::SRC_LAST ? hbt_pkg::SRC_LAST : cl);
    lo = fl[hbt_pkg::COORD_W-1:0];
    hi = cl[hbt_pkg::COORD_W-1:0];
    whi = fr != 0 ? fr << 8 : 65536;
    wlo = 65536 - whi;
  endfunction

  function automatic taps_t map_pixel(pixel_t px);
    taps_t  t;
    longint den, wxl, wxh, wyl, wyh, p;
    bit     clamped;
    clamped = 1'b0;
    den = row_sum(row_w, px.x, px.y);
    t = '{default: '0, status: hbt_pkg::STATUS_ZERO_DEN};
    if (den == 0) return t;
    split_axis(floor_quot(row_sum(row_x, px.x, px.y), den),
               t.x_low, t.x_high, wxl, wxh, clamped);
    split_axis(floor_quot(row_sum(row_y, px.x, px.y), den),
               t.y_low, t.y_high, wyl, wyh, clamped);
    p = (wxl * wyl) >> 16; t.w_ll = p[hbt_pkg::WEIGHT_W-1:0];
    p = (wxl * wyh) >> 16; t.w_lh = p[hbt_pkg::WEIGHT_W-1:0];
    p = (wxh * wyl) >> 16; t.w_hl = p[hbt_pkg::WEIGHT_W-1:0];
    p = (wxh * wyh) >> 16; t.w_hh = p[hbt_pkg::WEIGHT_W-1:0];
    t.status = clamped ? hbt_pkg::STATUS_CLAMPED : hbt_pkg::STATUS_OK;
    return t;
  endfunction

  function automatic logic [hbt_pkg::ROW_W-1:0] pack_row(int c0, int c1, int c2);
    logic [hbt_pkg::COEF_W-1:0] a, b, c;
    a = c0[hbt_pkg::COEF_W-1:0];
    b = c1[hbt_pkg::COEF_W-1:0];
    c = c2[hbt_pkg::COEF_W-1:0];
    return {a, b, c};
  endfunction

  function automatic logic [hbt_pkg::ROW_W-1:0] rand_row();
    return hbt_pkg::ROW_W'({$urandom, $urandom});
  endfunction

  function automatic void add_pixel(pixel_t p);
    pixel_queue.insert(pixel_queue.size(), p);
  endfunction

  // Pixel driver: hold an offer until taken, otherwise idle at random.
  always @(posedge clk) begin
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      taps_expected.insert(taps_expected.size(), map_pixel(pixel_queue.pop_front()));
      pixels_sent++;
      offer_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pix_bus.valid <= 1'b0;
    end else if (!(pix_bus.valid && !offer_taken)) begin
      if (pixel_queue.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
        pix_bus.valid <= 1'b1;
        pix_bus.out_x <= pixel_queue[0].x;
        pix_bus.out_y <= pixel_queue[0].y;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
    offer_taken = 1'b0;
  end

  // Result sink: random stalls plus one long hold-off to back up the pipe.
  always @(negedge clk) begin
    logic rdy;
    if (rst) begin
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!stall_done && pixels_sent >= 200) begin
      stall_done = 1'b1;
      stall_left = 250;
      rdy = 1'b0;
    end else begin
      rdy = steady || $urandom_range(99) >= 30;
    end
    taps_bus.ready <= rdy;
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    taps_t e;
    if (!rst && taps_bus.valid && taps_bus.ready) begin
      taps_seen++;
      if (taps_expected.size() == 0) begin
        $error("result beat with no pixel pending");
        errors++;
      end else begin
        e = taps_expected.pop_front();
        check_field("src_x_low", e.x_low, taps_bus.src_x_low);
        check_field("src_x_high", e.x_high, taps_bus.src_x_high);
        check_field("src_y_low", e.y_low, taps_bus.src_y_low);
        check_field("src_y_high", e.y_high, taps_bus.src_y_high);
        check_field("weight_ll", e.w_ll, taps_bus.weight_ll);
        check_field("weight_lh", e.w_lh, taps_bus.weight_lh);
        check_field("weight_hl", e.w_hl, taps_bus.weight_hl);
        check_field("weight_hh", e.w_hh, taps_bus.weight_hh);
        check_field("map_status", e.status, taps_bus.map_status);
        status_seen[e.status]++;
      end
    end
  end

  task automatic write_rows(logic [hbt_pkg::ROW_W-1:0] rx, logic [hbt_pkg::ROW_W-1:0] ry,
                            logic [hbt_pkg::ROW_W-1:0] rw, bit with_unused);
    logic [hbt_pkg::ROW_W-1:0] vals[4];
    logic [hbt_pkg::CFG_IDX_W-1:0] idx[4];
    int n;
    vals = '{rx, ry, rw, rand_row()};
    idx = '{hbt_pkg::CFG_ROW_X, hbt_pkg::CFG_ROW_Y, hbt_pkg::CFG_ROW_W, CFG_UNUSED};
    n = with_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
      case (idx[i])
        hbt_pkg::CFG_ROW_X: row_x = vals[i];
        hbt_pkg::CFG_ROW_Y: row_y = vals[i];
        hbt_pkg::CFG_ROW_W: row_w = vals[i];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || taps_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.x = hbt_pkg::COORD_W'($urandom_range(4095));
    p.y = hbt_pkg::COORD_W'($urandom_range(4095));
    return p;
  endfunction

  initial begin
    pixel_t p;
    int     sc, dg;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = hbt_pkg::CFG_ROW_X;
    cfg_bus.data  = '0;
    pix_bus.valid = 1'b0;
    pix_bus.out_x = '0;
    pix_bus.out_y = '0;
    taps_bus.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset rows: corners, then single-bit x with the complement as y.
    add_pixel('{12'd0, 12'd0});
    add_pixel('{12'd4095, 12'd4095});
    add_pixel('{12'd0, 12'd4095});
    add_pixel('{12'd4095, 12'd0});
    for (int b = 0; b < hbt_pkg::COORD_W; b++) add_pixel('{12'd1 << b, ~(12'd1 << b)});
    wait_drained();

    // Unit scale with a fractional shift, then an offset that pushes off the source.
    write_rows(pack_row(1024, 0, 384), pack_row(0, 1024, -128), pack_row(0, 0, 1 << 19), 1);
    for (int i = 0; i < 4; i++)
      add_pixel('{hbt_pkg::COORD_W'(4095 - i), hbt_pkg::COORD_W'(i)});
    add_pixel('{12'd0, 12'd0});
    wait_drained();

    // Zero homogeneous row, then all-extreme coefficients.
    write_rows(pack_row(-1048576, 1048575, -1048576), pack_row(1048575, -1048576, 1048575),
               '0, 0);
    add_pixel('{12'd5, 12'd9});
    add_pixel('{12'd4095, 12'd4095});
    wait_drained();
    write_rows({hbt_pkg::ROW_W{1'b1}}, pack_row(1048575, 1048575, 1048575),
               pack_row(-1048576, 1048575, -1048576), 0);
    add_pixel('{12'd0, 12'd0});
    add_pixel('{12'd4095, 12'd0});
    add_pixel('{12'd0, 12'd4095});
    wait_drained();

    // Random phases: mostly plausible warps, some with a vanishing denominator.
    for (int ph = 0; ph < 6; ph++) begin
      sc = $urandom_range(3072, 512);
      dg = (ph == 3) ? 1 : 0;
      if (ph == 5)
        write_rows(rand_row(), rand_row(), rand_row(), 1);
      else if (dg)
        write_rows(pack_row(sc, 37, 4096), pack_row(-53, sc, 1000), pack_row(64, -64, 0), 0);
      else
        write_rows(pack_row(sc + $urandom_range(256) - 128, $urandom_range(400) - 200,
                            $urandom_range(8192) - 4096),
                   pack_row($urandom_range(400) - 200, sc, $urandom_range(8192) - 4096),
                   pack_row($urandom_range(64) - 32, $urandom_range(64) - 32,
                            (1 << 19) + $urandom_range(131072) - 65536), ph == 0);
      steady = (ph == 2);
      for (int i = 0; i < 70; i++) begin
        p = rand_pixel();
        if (dg && $urandom_range(2) == 0) p.y = p.x;
        add_pixel(p);
      end
      wait_drained();
    end
    steady = 1'b0;

    $display("covered %0d pixels, %0d results: %0d ok, %0d clamped, %0d zero denominator",
             pixels_sent, taps_seen, status_seen[hbt_pkg::STATUS_OK],
             status_seen[hbt_pkg::STATUS_CLAMPED], status_seen[hbt_pkg::STATUS_ZERO_DEN]);
    $display("matrix settings included reset, unit, extremes, zero and random rows");
    if (errors == 0 && taps_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
